// File: rtl/voxel_chebyshev_distance_fill_defines.svh
// Assertion macros for the voxel distance fill block.
// Used by the port checker; depends on nothing else.
`ifndef VOXEL_CHEBYSHEV_DISTANCE_FILL_DEFINES_SVH
`define VOXEL_CHEBYSHEV_DISTANCE_FILL_DEFINES_SVH

// Antecedent holds at one edge, consequent at the same edge.
`define VCDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds at one edge, consequent at the next edge.
`define VCDF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/vcdf_pkg.sv
// Shared types and constants for the voxel distance fill block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vcdf_pkg;

  localparam int DATA_W  = 8;   // voxel value width
  localparam int COORD_W = 5;   // coordinate field width on the ports
  localparam int RAD_W   = 7;   // radius width, MAX_RADIUS up to 128

  localparam int DefGridWidth  = 32;
  localparam int DefGridHeight = 32;
  localparam int DefMaxRadius  = 64;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef struct packed {
    logic             done;
    logic [RAD_W-1:0] radius;
  } scan_rsp_t;

endpackage

`default_nettype wire

// File: rtl/voxel_chebyshev_distance_fill.sv
// Voxel store with write, read and nearest-solid distance fill.
// Uses vcdf_pkg, vcdf_ram and vcdf_scan.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one item (action_i, pos_x_i,
//   pos_y_i, pos_z_i, write_value_i); a beat moves when valid is high and
//   stall is low. Output channel: out_valid_o / out_stall_i carry one
//   voxel_value_o per item, in item order.
//   Action 0 writes the voxel, 1 fills an empty voxel with (radius - 1) of the
//   nearest solid voxel (0 when none is in reach), 2 and 3 read it. Every item
//   returns the voxel value afterwards; coordinates off the grid return 0.
//   One item is worked on at a time. Write, read and fill on a non-empty
//   voxel pass from accept through ST_LOOK and ST_RESP to the output stage.
//   A fill on an empty voxel sweeps the whole grid through the single RAM
//   read port, one voxel per cycle, in ST_SCAN before it reaches ST_RESP.
//   After reset the RAM is swept to zero, one entry per cycle, over all
//   2**(2*clog2(GRID_WIDTH)+clog2(GRID_HEIGHT)) entries (32768 at default);
//   in_stall_o stays high meanwhile. While out_stall_i is high the result
//   holds; a finished result waits in its own stage until the output frees.
`timescale 1ns / 1ps
`default_nettype none

module voxel_chebyshev_distance_fill
  import vcdf_pkg::*;
#(
  parameter int GRID_WIDTH  = DefGridWidth,
  parameter int GRID_HEIGHT = DefGridHeight,
  parameter int MAX_RADIUS  = DefMaxRadius
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               action_i,
  input  wire logic [COORD_W-1:0]       pos_x_i,
  input  wire logic [COORD_W-1:0]       pos_y_i,
  input  wire logic [COORD_W-1:0]       pos_z_i,
  input  wire logic signed [DATA_W-1:0] write_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic signed [DATA_W-1:0]      voxel_value_o
);

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int ZW = $clog2(GRID_HEIGHT);
  localparam int AW = 2 * XW + ZW;
  localparam int MW = (XW > ZW) ? XW : ZW;
  localparam int CW = (MW > COORD_W) ? MW : COORD_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  action_e             act_q;
  logic [XW-1:0]       tx_q, ty_q;
  logic [ZW-1:0]       tz_q;
  logic [DATA_W-1:0]   wval_q;
  logic                oob_q;
  logic [DATA_W-1:0]   res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;

  logic                accept;
  logic [CW-1:0]       x_c, y_c, z_c;
  logic                oob_in;
  logic [AW-1:0]       tgt_addr_in, tgt_addr;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  logic                scan_start, scan_re;
  logic [AW-1:0]       scan_raddr;
  scan_rsp_t           scan_rsp;
  logic [DATA_W-1:0]   fill_val;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign x_c    = CW'(pos_x_i);
  assign y_c    = CW'(pos_y_i);
  assign z_c    = CW'(pos_z_i);
  assign oob_in = ({1'b0, x_c} >= (CW + 1)'(GRID_WIDTH))
               || ({1'b0, y_c} >= (CW + 1)'(GRID_WIDTH))
               || ({1'b0, z_c} >= (CW + 1)'(GRID_HEIGHT));

  assign tgt_addr_in = {z_c[ZW-1:0], y_c[XW-1:0], x_c[XW-1:0]};
  assign tgt_addr    = {tz_q, ty_q, tx_q};

  // The found radius r is stored as r - 1; no solid in reach leaves it empty.
  assign fill_val = (scan_rsp.radius == '0) ? '0 : DATA_W'(scan_rsp.radius - 1'b1);

  assign ram_re    = accept || scan_re;
  assign ram_raddr = accept ? tgt_addr_in : scan_raddr;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = tgt_addr;
    ram_wdata   = wval_q;
    scan_start  = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_d = ST_RESP;
        if (oob_q) begin
          res_d = '0;
        end else begin
          case (act_q)
            ACT_WRITE: begin
              ram_we = 1'b1;
              res_d  = wval_q;
            end
            ACT_FILL: begin
              res_d = ram_rdata;
              if (ram_rdata == '0) begin
                scan_start = 1'b1;
                state_d    = ST_SCAN;
              end
            end
            default: begin
              res_d = ram_rdata;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          ram_we    = 1'b1;
          ram_wdata = fill_val;
          res_d     = fill_val;
          state_d   = ST_RESP;
        end
      end
      ST_RESP: begin
        // Hold until the output stage is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_e'(action_i);
      tx_q   <= x_c[XW-1:0];
      ty_q   <= y_c[XW-1:0];
      tz_q   <= z_c[ZW-1:0];
      wval_q <= write_value_i;
      oob_q  <= oob_in;
    end
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign voxel_value_o = out_data_q;

  vcdf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(2 ** AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  vcdf_scan #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .tgt_x_i  (tx_q),
    .tgt_y_i  (ty_q),
    .tgt_z_i  (tz_q),
    .rd_en_o  (scan_re),
    .rd_addr_o(scan_raddr),
    .rd_data_i(ram_rdata),
    .rsp_o    (scan_rsp)
  );

endmodule

`default_nettype wire

// File: rtl/vcdf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/vcdf_scan.sv
// Nearest-solid search: sweeps the grid one voxel per cycle through the RAM
// read port and tracks the smallest Chebyshev distance. Uses vcdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcdf_scan
  import vcdf_pkg::*;
#(
  parameter int GRID_WIDTH  = DefGridWidth,
  parameter int GRID_HEIGHT = DefGridHeight,
  parameter int MAX_RADIUS  = DefMaxRadius,
  localparam int XW = $clog2(GRID_WIDTH),
  localparam int ZW = $clog2(GRID_HEIGHT),
  localparam int AW = 2 * XW + ZW
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [XW-1:0]     tgt_x_i,
  input  wire logic [XW-1:0]     tgt_y_i,
  input  wire logic [ZW-1:0]     tgt_z_i,
  output logic                   rd_en_o,
  output logic      [AW-1:0]     rd_addr_o,
  input  wire logic [DATA_W-1:0] rd_data_i,
  output scan_rsp_t              rsp_o
);

  localparam int MW = (XW > ZW) ? XW : ZW;
  localparam int DW = (MW > RAD_W) ? MW : RAD_W;
  localparam logic [XW-1:0] XMax = XW'(GRID_WIDTH - 1);
  localparam logic [ZW-1:0] ZMax = ZW'(GRID_HEIGHT - 1);
  localparam logic [DW-1:0] DMax = DW'(MAX_RADIUS - 1);

  logic             run_q;
  logic [XW-1:0]    sx_q, sy_q;
  logic [ZW-1:0]    sz_q;
  logic             last_issue;

  logic             v1_q, last1_q;
  logic [XW-1:0]    cx1_q, cy1_q;
  logic [ZW-1:0]    cz1_q;

  logic [DW-1:0]    dx, dy, dz, dxy, cheb_d;
  logic             v2_q, hit2_q, last2_q;
  logic [DW-1:0]    d2_q;

  logic [RAD_W-1:0] best_q, best_d;
  logic             done_q;
  logic [RAD_W-1:0] radius_q;

  function automatic logic [DW-1:0] abs_diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Issue stage: walk x fastest, then y, then z.
  assign last_issue = (sx_q == XMax) && (sy_q == XMax) && (sz_q == ZMax);
  assign rd_en_o    = run_q;
  assign rd_addr_o  = {sz_q, sy_q, sx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
    end else if (run_q) begin
      if (last_issue) begin
        run_q <= 1'b0;
      end
      if (sx_q == XMax) begin
        sx_q <= '0;
        if (sy_q == XMax) begin
          sy_q <= '0;
          sz_q <= sz_q + 1'b1;
        end else begin
          sy_q <= sy_q + 1'b1;
        end
      end else begin
        sx_q <= sx_q + 1'b1;
      end
    end
  end

  // Read data stage: the coordinates are registered in step with the RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
    end else begin
      v1_q    <= run_q && !start_i;
      last1_q <= run_q && !start_i && last_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    cx1_q <= sx_q;
    cy1_q <= sy_q;
    cz1_q <= sz_q;
  end

  assign dx     = abs_diff(DW'(cx1_q), DW'(tgt_x_i));
  assign dy     = abs_diff(DW'(cy1_q), DW'(tgt_y_i));
  assign dz     = abs_diff(DW'(cz1_q), DW'(tgt_z_i));
  assign dxy    = (dy > dx) ? dy : dx;
  assign cheb_d = (dz > dxy) ? dz : dxy;

  // Distance stage: keep only solid voxels at radius 1..MAX_RADIUS-1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      hit2_q  <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      v2_q    <= v1_q;
      hit2_q  <= v1_q && rd_data_i[DATA_W-1] && (cheb_d != '0) && (cheb_d <= DMax);
      last2_q <= v1_q && last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q <= cheb_d;
  end

  // Minimum stage.
  always_comb begin
    best_d = best_q;
    if (v2_q && hit2_q && ((best_q == '0) || (RAD_W'(d2_q) < best_q))) begin
      best_d = RAD_W'(d2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      done_q <= 1'b0;
    end else begin
      best_q <= start_i ? '0 : best_d;
      done_q <= last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    radius_q <= best_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.radius = radius_q;

endmodule

`default_nettype wire

// File: rtl/vcdf_chk.sv
// Port checker for the voxel distance fill block, bound to the top level.
// Uses vcdf_pkg and voxel_chebyshev_distance_fill_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_chebyshev_distance_fill_defines.svh"

module vcdf_chk
  import vcdf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [DATA_W-1:0] voxel_value_o
);

  // A stalled result beat holds.
  `VCDF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(voxel_value_o), "stalled result beat changed")

  // One item at a time: after an accepted beat the input stalls.
  `VCDF_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input accepted while an item is in flight")

  // A new result only comes from an item in flight.
  `VCDF_ASSERT_NOW(a_out_from_item, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o), "result without an item in flight")

endmodule

bind voxel_chebyshev_distance_fill vcdf_chk u_chk (.*);

`default_nettype wire

// File: test/tb_voxel_chebyshev_distance_fill.sv
// Self-checking testbench for voxel_chebyshev_distance_fill.
// Uses vcdf_pkg; runs directed rows, then random write/fill/read traffic checked
// against a local voxel store and nearest-solid search.
`timescale 1ns / 1ps

module tb_voxel_chebyshev_distance_fill;
  import vcdf_pkg::*;

  localparam int GRID_W      = DefGridWidth;
  localparam int GRID_H      = DefGridHeight;
  localparam int MAX_RAD     = DefMaxRadius;
  localparam int CELLS       = GRID_W * GRID_W * GRID_H;
  localparam int DIR_N       = 21;
  localparam int RAND_N      = 78;
  localparam int PHASE_LEN   = 26;
  localparam int TOTAL_OPS   = DIR_N + RAND_N;
  localparam int EMPTY_FILLS = 15;           // each costs a full grid sweep
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYC   = 16;

  localparam logic [1:0] ACT_SPARE = 2'd3;   // unused code, behaves as a read

  typedef struct packed {
    logic [1:0]               action;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
    logic [COORD_W-1:0]       z;
    logic signed [DATA_W-1:0] wval;
  } voxel_op_t;

  typedef struct packed {
    voxel_op_t                op;
    logic                     typed;
    logic signed [DATA_W-1:0] value;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               action_i;
  logic [COORD_W-1:0]       pos_x_i;
  logic [COORD_W-1:0]       pos_y_i;
  logic [COORD_W-1:0]       pos_z_i;
  logic signed [DATA_W-1:0] write_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] voxel_value_o;

  logic signed [DATA_W-1:0] vox_mem [CELLS];
  logic signed [DATA_W-1:0] expected_voxels [$];

  voxel_op_t cur_op;
  int        op_idx;
  int        empty_fills_left;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        fail_cnt;
  int        cycle_cnt;
  bit        stim_done;

  dir_row_t dir_tab [DIR_N] = '{
    '{'{ACT_READ,  5'd0,  5'd0,  5'd0,     8'sd0}, 1'b1,    8'sd0},
    '{'{ACT_READ,  5'd31, 5'd31, 5'd31,    8'sd0}, 1'b1,    8'sd0},
    // nothing solid anywhere yet: fill leaves the voxel empty
    '{'{ACT_FILL,  5'd5,  5'd5,  5'd5,     8'sd0}, 1'b1,    8'sd0},
    '{'{ACT_WRITE, 5'd0,  5'd0,  5'd0,  -8'sd128}, 1'b1, -8'sd128},
    '{'{ACT_WRITE, 5'd31, 5'd31, 5'd31,  8'sd127}, 1'b1,  8'sd127},
    '{'{ACT_SPARE, 5'd31, 5'd31, 5'd31,    8'sd0}, 1'b1,  8'sd127},
    '{'{ACT_FILL,  5'd0,  5'd0,  5'd0,     8'sd0}, 1'b1, -8'sd128},
    '{'{ACT_FILL,  5'd31, 5'd31, 5'd31,    8'sd0}, 1'b1,  8'sd127},
    '{'{ACT_WRITE, 5'd10, 5'd10, 5'd10,   -8'sd1}, 1'b1,   -8'sd1},
    '{'{ACT_FILL,  5'd12, 5'd10, 5'd10,    8'sd0}, 1'b0,    8'sd0},
    // neighbor of a solid voxel: radius 1 stores 0
    '{'{ACT_FILL,  5'd11, 5'd11, 5'd11,    8'sd0}, 1'b0,    8'sd0},
    '{'{ACT_READ,  5'd11, 5'd11, 5'd11,    8'sd0}, 1'b0,    8'sd0},
    '{'{ACT_FILL,  5'd31, 5'd0,  5'd31,    8'sd0}, 1'b0,    8'sd0},
    '{'{ACT_WRITE, 5'd16, 5'd16, 5'd16,    8'sd0}, 1'b1,    8'sd0},
    '{'{ACT_WRITE, 5'd1,  5'd2,  5'd3,    8'sd85}, 1'b1,   8'sd85},
    '{'{ACT_WRITE, 5'd30, 5'd29, 5'd28,  -8'sd86}, 1'b1,  -8'sd86},
    '{'{ACT_READ,  5'd1,  5'd2,  5'd3,     8'sd0}, 1'b1,   8'sd85},
    '{'{ACT_FILL,  5'd0,  5'd31, 5'd0,     8'sd0}, 1'b0,    8'sd0},
    '{'{ACT_FILL,  5'd12, 5'd10, 5'd10,    8'sd0}, 1'b0,    8'sd0},
    '{'{ACT_WRITE, 5'd0,  5'd0,  5'd0,     8'sd0}, 1'b1,    8'sd0},
    '{'{ACT_READ,  5'd0,  5'd0,  5'd0,     8'sd0}, 1'b1,    8'sd0}
  };

  voxel_chebyshev_distance_fill #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H),
    .MAX_RADIUS (MAX_RAD)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .voxel_value_o(voxel_value_o)
  );

  function automatic int cell_of(voxel_op_t op);
    return int'(op.x) + int'(op.y) * GRID_W + int'(op.z) * GRID_W * GRID_W;
  endfunction

  // Smallest Chebyshev distance from the target to a solid voxel, 0 if none.
  function automatic int nearest_solid_dist(int tx, int ty, int tz);
    int best;
    int d;
    int dy;
    int dz;
    best = 0;
    for (int z = 0; z < GRID_H; z++) begin
      for (int y = 0; y < GRID_W; y++) begin
        for (int x = 0; x < GRID_W; x++) begin
          if (vox_mem[x + y * GRID_W + z * GRID_W * GRID_W][DATA_W-1]) begin
            d  = (x > tx) ? x - tx : tx - x;
            dy = (y > ty) ? y - ty : ty - y;
            dz = (z > tz) ? z - tz : tz - z;
            if (dy > d) d = dy;
            if (dz > d) d = dz;
            if (d >= 1 && d <= MAX_RAD - 1 && (best == 0 || d < best)) best = d;
          end
        end
      end
    end
    return best;
  endfunction

  function automatic logic signed [DATA_W-1:0] apply_voxel_op(voxel_op_t op);
    int idx;
    int r;
    if (op.x >= GRID_W || op.y >= GRID_W || op.z >= GRID_H) return '0;
    idx = cell_of(op);
    case (op.action)
      ACT_WRITE: vox_mem[idx] = op.wval;
      ACT_FILL: begin
        if (vox_mem[idx] == 0) begin
          r            = nearest_solid_dist(op.x, op.y, op.z);
          vox_mem[idx] = (r == 0) ? '0 : DATA_W'(r - 1);
        end
      end
      default: ;
    endcase
    return vox_mem[idx];
  endfunction

  // Mostly a small cluster so fills find close solids; the rest spans the grid.
  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(99) < 70) return COORD_W'($urandom_range(15, 8));
    return COORD_W'($urandom_range(31, 0));
  endfunction

  function automatic voxel_op_t random_voxel_op();
    voxel_op_t op;
    int        roll;
    op.x   = pick_coord();
    op.y   = pick_coord();
    op.z   = pick_coord();
    op.wval = '0;
    roll   = $urandom_range(99);
    if (roll < 35) begin
      op.action = ACT_WRITE;
      case ($urandom_range(3))
        0, 1:    op.wval = DATA_W'(-$urandom_range(128, 1));
        2:       op.wval = '0;
        default: op.wval = DATA_W'($urandom_range(255));
      endcase
    end else if (roll < 70) begin
      op.action = ACT_FILL;
      if (vox_mem[cell_of(op)] == 0) begin
        // hold the number of full sweeps down; fall back to a read
        if (empty_fills_left == 0) op.action = ACT_READ;
        else empty_fills_left--;
      end
    end else if (roll < 90) begin
      op.action = ACT_READ;
    end else begin
      op.action = ACT_SPARE;
    end
    return op;
  endfunction

  function automatic void set_phase(int idx);
    int ph;
    ph = (idx < DIR_N) ? 0 : (idx - DIR_N) / PHASE_LEN;
    case (ph)
      0: begin
        tx_idle_pct = 36;
        rx_idle_pct = 84;
      end
      1: begin
        tx_idle_pct = 84;
        rx_idle_pct = 36;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endfunction

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = ACT_READ;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    write_value_i = '0;
    out_stall_i   = 1'b0;
    for (int i = 0; i < CELLS; i++) vox_mem[i] = '0;
    op_idx           = 0;
    empty_fills_left = EMPTY_FILLS;
    fail_cnt         = 0;
    cycle_cnt        = 0;
    stim_done        = 1'b0;
    set_phase(0);
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Sender: predict on each accepted beat, then offer the next item or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (op_idx <= DIR_N && dir_tab[op_idx-1].typed) begin
          void'(apply_voxel_op(cur_op));
          expected_voxels.insert(expected_voxels.size(), dir_tab[op_idx-1].value);
        end else begin
          expected_voxels.insert(expected_voxels.size(), apply_voxel_op(cur_op));
        end
        if (op_idx == TOTAL_OPS) stim_done = 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (op_idx < TOTAL_OPS && $urandom_range(99) >= tx_idle_pct) begin
          cur_op = (op_idx < DIR_N) ? dir_tab[op_idx].op : random_voxel_op();
          op_idx++;
          set_phase(op_idx);
          in_valid_i    <= 1'b1;
          action_i      <= cur_op.action;
          pos_x_i       <= cur_op.x;
          pos_y_i       <= cur_op.y;
          pos_z_i       <= cur_op.z;
          write_value_i <= cur_op.wval;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted beat against the oldest expectation.
  always @(posedge clk_i) begin : rx_check
    logic signed [DATA_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_voxels.size() == 0) begin
          $error("voxel_value: expected none, got %0d", voxel_value_o);
          fail_cnt++;
        end else begin
          want = expected_voxels.pop_front();
          if (voxel_value_o !== want) begin
            $error("voxel_value: expected %0d, got %0d", want, voxel_value_o);
            fail_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    while (!(stim_done && expected_voxels.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
